### rtl/osm_pkg.sv
// ---------------------------------------------------------------------------
// osm_pkg: shared types and constants of the overlapping substring matcher
// Holds default sizes, the configuration register map and the result item
// layout used by the result queue.
// ---------------------------------------------------------------------------
package osm_pkg;

	// default sizes
	localparam int unsigned TEXT_MAX_DEF    = 65536;
	localparam int unsigned PATTERN_MAX_DEF = 8;

	// field widths
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned PAT_W     = 64;
	localparam int unsigned LEN_W     = 4;
	localparam int unsigned LIMIT_W   = 8;
	localparam int unsigned TOTAL_W   = 9;
	localparam int unsigned START_W   = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 64;
	localparam int unsigned S_DATA_W  = 8;
	localparam int unsigned M_DATA_W  = 32;

	// result queue
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_BYTES  = 2'd0,
		REG_PATTERN_LENGTH = 2'd1,
		REG_MAX_REPORTS    = 2'd2
	} cfg_reg_t;

	// one result item
	typedef struct packed {
		logic               is_total;
		logic [START_W-1:0] match_start;
		logic [TOTAL_W-1:0] match_total;
		logic               last_of_run;
	} result_t;

endpackage

### rtl/overlapping_substring_matcher.sv
// ---------------------------------------------------------------------------
// overlapping_substring_matcher: streaming search for all pattern occurrences
// Compares a window of the newest text bytes against a configured pattern
// and reports match start offsets, then a saturated match count per text.
// ---------------------------------------------------------------------------
// Usage: text bytes enter one per item on the slave side, tlast on the final
// byte of a text. Each byte is compared in the cycle it is accepted, so the
// block takes one byte per clock as long as results drain. A byte yields no
// result, a match position (tuser 0), a count (tuser 1), or a position then a
// count; results are registered into a four-entry queue when their byte
// is accepted, and tlast marks the final result of each byte. Input tready is
// high while the queue has at least two free entries, so a stalled master
// side stops the slave side once three or four result items are waiting;
// bytes without a result never fill it. A byte with at most one result keeps
// one item per cycle flowing; a byte with both a position and a count
// queues two items. Configuration is written through the plain write port
// while no text is in progress; after a text's count the window, byte counter
// and match counter return to zero. Bytes past TEXT_MAX are not compared.
// ---------------------------------------------------------------------------
module overlapping_substring_matcher #(
	parameter int unsigned TEXT_MAX    = osm_pkg::TEXT_MAX_DEF,
	parameter int unsigned PATTERN_MAX = osm_pkg::PATTERN_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_wr_en,
	input  logic [osm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [osm_pkg::CFG_W-1:0]      cfg_data,
	// text input
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [osm_pkg::S_DATA_W-1:0]   s_tdata,   // [7:0] text_byte
	input  logic                           s_tlast,   // end_of_text
	// result output
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [osm_pkg::M_DATA_W-1:0]   m_tdata,   // [15:0] match_start,
	                                                  // [24:16] match_total, rest 0
	output logic                           m_tuser,   // is_total
	output logic                           m_tlast    // last_of_run
);
	import osm_pkg::*;

	localparam int unsigned CNT_W  = $clog2(TEXT_MAX + 1);
	localparam int unsigned OFFS_W = (CNT_W > START_W) ? CNT_W : START_W;

	// configuration registers
	logic [PAT_W-1:0]   pattern_q;
	logic [LEN_W-1:0]   pat_len_q;
	logic [LIMIT_W-1:0] max_rep_q;

	// text state
	logic [BYTE_W-1:0]  win_q [PATTERN_MAX];
	logic [CNT_W-1:0]   seen_q;
	logic [TOTAL_W-1:0] found_q;

	// result queue
	result_t            queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	// per-item logic
	logic               in_acc;
	logic               out_acc;
	logic               active;
	logic [LEN_W-1:0]   len_eff;
	logic [BYTE_W-1:0]  win_new [PATTERN_MAX];
	logic [CNT_W-1:0]   seen_inc;
	logic               eq;
	logic               hit;
	logic               report;
	logic [TOTAL_W-1:0] found_upd;
	logic [OFFS_W-1:0]  offs;
	logic [LEN_W-1:0]   pidx;
	result_t            pos_res;
	result_t            tot_res;
	logic [1:0]         push_n;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			pat_len_q <= LEN_W'(1);
			max_rep_q <= LIMIT_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PATTERN_BYTES:  pattern_q <= cfg_data;
				REG_PATTERN_LENGTH: pat_len_q <= cfg_data[LEN_W-1:0];
				REG_MAX_REPORTS:    max_rep_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// effective pattern length, clamped to 1..PATTERN_MAX
	always_comb begin
		if (pat_len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (pat_len_q > LEN_W'(PATTERN_MAX)) begin
			len_eff = LEN_W'(PATTERN_MAX);
		end else begin
			len_eff = pat_len_q;
		end
	end

	// shifted window, newest byte at index 0
	always_comb begin
		for (int b = 0; b < PATTERN_MAX; b++) begin
			if (b == 0) begin
				win_new[b] = s_tdata[BYTE_W-1:0];
			end else begin
				win_new[b] = win_q[b-1];
			end
		end
	end

	// window compare: window byte b pairs with pattern byte len-1-b
	always_comb begin
		eq   = 1'b1;
		pidx = '0;
		for (int b = 0; b < PATTERN_MAX; b++) begin
			pidx = len_eff - LEN_W'(1) - LEN_W'(b);
			if (LEN_W'(b) < len_eff &&
			    win_new[b] != pattern_q[BYTE_W*pidx[2:0] +: BYTE_W]) begin
				eq = 1'b0;
			end
		end
	end

	// match decision and counters
	always_comb begin
		active    = seen_q < CNT_W'(TEXT_MAX);
		seen_inc  = seen_q + CNT_W'(1);
		hit       = active && (seen_inc >= CNT_W'(len_eff)) && eq;
		report    = hit && (found_q < TOTAL_W'(max_rep_q));
		found_upd = found_q;
		if (hit && (found_q < (TOTAL_W'(max_rep_q) + TOTAL_W'(1)))) begin
			found_upd = found_q + TOTAL_W'(1);
		end
		offs = OFFS_W'(seen_inc) - OFFS_W'(len_eff);
	end

	// result items of this byte
	always_comb begin
		pos_res.is_total    = 1'b0;
		pos_res.match_start = offs[START_W-1:0];
		pos_res.match_total = '0;
		pos_res.last_of_run = !s_tlast;
		tot_res.is_total    = 1'b1;
		tot_res.match_start = '0;
		tot_res.match_total = found_upd;
		tot_res.last_of_run = 1'b1;
		push_n = 2'(report) + 2'(s_tlast);
		if (!in_acc) begin
			push_n = '0;
		end
	end

	// text state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < PATTERN_MAX; b++) begin
				win_q[b] <= '0;
			end
			seen_q  <= '0;
			found_q <= '0;
		end else if (in_acc) begin
			if (s_tlast) begin
				for (int b = 0; b < PATTERN_MAX; b++) begin
					win_q[b] <= '0;
				end
				seen_q  <= '0;
				found_q <= '0;
			end else if (active) begin
				for (int b = 0; b < PATTERN_MAX; b++) begin
					win_q[b] <= win_new[b];
				end
				seen_q  <= seen_inc;
				found_q <= found_upd;
			end
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (report) begin
				queue_q[wr_ptr_q] <= pos_res;
				if (s_tlast) begin
					queue_q[wr_ptr_q + QPTR_W'(1)] <= tot_res;
				end
			end else if (s_tlast) begin
				queue_q[wr_ptr_q] <= tot_res;
			end
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push_n) - QCNT_W'(out_acc);
		end
	end

	// handshake and output fields
	assign s_tready = count_q <= QCNT_W'(QUEUE_DEPTH - 2);
	assign m_tvalid = count_q != '0;
	assign m_tdata  = {{(M_DATA_W - START_W - TOTAL_W){1'b0}},
	                   queue_q[rd_ptr_q].match_total,
	                   queue_q[rd_ptr_q].match_start};
	assign m_tuser  = queue_q[rd_ptr_q].is_total;
	assign m_tlast  = queue_q[rd_ptr_q].last_of_run;

endmodule
